// ----- rtl/mat_pkg.sv -----
// Shared types and constants for the multi-alarm timeout timer.
package mat_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int TIME_W        = 32;
  localparam int TIMEOUT_W     = 16;
  localparam int OPCODE_W      = 2;
  localparam int INDEX_W       = 3;
  localparam int IDX_EXT_W     = 7;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

  localparam logic [OPCODE_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_ARM    = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CANCEL = 2'd2;

  typedef struct packed {
    logic [INDEX_W-1:0] fired_index;
    logic               last_fired;
  } emit_t;

endpackage

// ----- rtl/mat_slot_ram.sv -----
// Deadline store: one write port, one read port with registered read data.
module mat_slot_ram import mat_pkg::*; #(
  parameter int DEPTH = NUM_SLOTS_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [TIME_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [TIME_W-1:0] rdata
);

  logic [TIME_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/mat_ctrl.sv -----
// Request decode, time counter, active flags and slot scan sequencer.
module mat_ctrl import mat_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF,
  parameter int SW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_ready,
  input  logic [OPCODE_W-1:0]  opcode,
  input  logic [INDEX_W-1:0]   alarm_index,
  input  logic [TIMEOUT_W-1:0] timeout_ticks,
  output logic                 emit_valid,
  input  logic                 emit_ready,
  output emit_t                emit
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  localparam logic [SW-1:0]        LAST_SLOT = SW'(NUM_SLOTS - 1);
  localparam logic [IDX_EXT_W-1:0] SLOTS_EXT = IDX_EXT_W'(NUM_SLOTS);

  logic [1:0]           state;
  logic [TIME_W-1:0]    cur_time;
  logic [NUM_SLOTS-1:0] active;
  logic [SW-1:0]        scan_idx;
  logic [SW-1:0]        pend_idx;
  logic                 pend_valid;

  logic                 accept;
  logic [IDX_EXT_W-1:0] idx_ext;
  logic [SW-1:0]        req_slot;
  logic                 idx_ok;
  logic                 ram_we;
  logic [TIME_W-1:0]    ram_wdata;
  logic                 ram_re;
  logic [SW-1:0]        ram_raddr;
  logic [TIME_W-1:0]    ram_rdata;
  logic [TIME_W-1:0]    diff;
  logic                 due;
  logic                 advance;
  logic [IDX_EXT_W-1:0] pend_ext;

  assign req_ready = (state == ST_IDLE);
  assign accept    = req_valid && req_ready;
  assign idx_ext   = IDX_EXT_W'(alarm_index);
  assign req_slot  = idx_ext[SW-1:0];
  assign idx_ok    = (idx_ext < SLOTS_EXT);

  assign ram_we    = accept && (opcode == OP_ARM) && idx_ok;
  assign ram_wdata = cur_time + TIME_W'(timeout_ticks);

  assign diff    = cur_time - ram_rdata;
  assign due     = active[scan_idx] && !diff[TIME_W-1];
  assign advance = !(due && pend_valid) || emit_ready;

  assign ram_re    = (state == ST_READ) ||
                     ((state == ST_EVAL) && advance && (scan_idx != LAST_SLOT));
  assign ram_raddr = (state == ST_READ) ? scan_idx : scan_idx + SW'(1);

  assign pend_ext         = IDX_EXT_W'(pend_idx);
  assign emit.fired_index = pend_ext[INDEX_W-1:0];
  assign emit.last_fired  = (state == ST_FLUSH);
  assign emit_valid       = pend_valid &&
                            (((state == ST_EVAL) && due) || (state == ST_FLUSH));

  mat_slot_ram #(
    .DEPTH (NUM_SLOTS),
    .AW    (SW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (req_slot),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cur_time   <= '0;
      active     <= '0;
      scan_idx   <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (opcode == OP_TICK) begin
              cur_time   <= cur_time + TIME_W'(1);
              scan_idx   <= '0;
              pend_valid <= 1'b0;
              state      <= ST_READ;
            end else if (idx_ok && (opcode == OP_ARM)) begin
              active[req_slot] <= 1'b1;
            end else if (idx_ok && (opcode == OP_CANCEL)) begin
              active[req_slot] <= 1'b0;
            end
          end
        end
        ST_READ: begin
          state <= ST_EVAL;
        end
        ST_EVAL: begin
          if (advance) begin
            if (due) begin
              active[scan_idx] <= 1'b0;
              pend_idx         <= scan_idx;
              pend_valid       <= 1'b1;
            end
            if (scan_idx == LAST_SLOT) begin
              state <= ST_FLUSH;
            end else begin
              scan_idx <= scan_idx + SW'(1);
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid || emit_ready) begin
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/multi_alarm_timeout_timer.sv -----
// Top level of the multi-alarm timeout timer: config register and output stage.
//
//   channel   direction  signals                         payload
//   s_axis    in         s_tvalid s_tready s_tdata s_tuser  alarm_index / opcode
//   cfg       in         cfg_valid cfg_ready cfg_data    timeout_ticks
//   m_axis    out        m_tvalid m_tready m_tdata m_tlast  fired_index / last_fired
//
// Arm and cancel complete on acceptance. A tick is accepted, then reads the first
// deadline, checks each slot in turn and flushes the last result; output stalls can hold it.
// The scan rate is set by the single read port of the deadline memory.
// Reset clears time and active flags at once; deadlines are masked by the flags.
// A full output stage holds the scan until m_tready; the output register lets
// the next request in while a result waits.
module multi_alarm_timeout_timer import mat_pkg::*; #(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [2:0] alarm_index, [7:3] zero
  input  logic [OPCODE_W-1:0]  s_tuser,   // [1:0] opcode
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [7:0]           m_tdata,   // [2:0] fired_index, [7:3] zero
  output logic                 m_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [TIMEOUT_W-1:0] cfg_data
);

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic                 emit_valid;
  logic                 emit_ready;
  emit_t                emit;
  logic [INDEX_W-1:0]   out_index;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      timeout_ticks <= cfg_data;
    end
  end

  mat_ctrl #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .req_valid     (s_tvalid),
    .req_ready     (s_tready),
    .opcode        (s_tuser),
    .alarm_index   (s_tdata[INDEX_W-1:0]),
    .timeout_ticks (timeout_ticks),
    .emit_valid    (emit_valid),
    .emit_ready    (emit_ready),
    .emit          (emit)
  );

  assign emit_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_ready) begin
      m_tvalid <= emit_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_ready && emit_valid) begin
      out_index <= emit.fired_index;
      m_tlast   <= emit.last_fired;
    end
  end

  assign m_tdata = {5'd0, out_index};

endmodule
